### src/mfrt_pkg.sv
// Package with the shared constants, codes and types of the mailbox unit.
`default_nettype none
package mfrt_pkg;

    localparam int CHANNELS      = 16;
    localparam int SLOTS         = 8;
    localparam int MSG_WIDTH     = 32;
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int PTR_W         = $clog2(SLOTS);
    localparam int ADDR_W        = CH_W + PTR_W;
    localparam int STORE_DEPTH   = CHANNELS * SLOTS;
    localparam int TIME_W        = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int OPCODE_W      = 2;
    localparam int CHANNEL_W     = 4;
    localparam int MESSAGE_W     = 32;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

    // Only bit 1 marks a tick, so code three also acts as a tick.
    localparam logic [OPCODE_W-1:0] OP_SEND     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RECV     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK_ALT = 2'd3;
    localparam int                  OP_TICK_BIT = 1;

    typedef enum logic [2:0] {
        ST_SENT       = 3'd0,
        ST_FULL       = 3'd1,
        ST_RECEIVED   = 3'd2,
        ST_WAIT_START = 3'd3,
        ST_WAITING    = 3'd4,
        ST_TIMEOUT    = 3'd5,
        ST_TICK       = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage
`default_nettype wire

### src/mfrt_in_if.sv
// Request channel interface: operation, channel and message word.
`default_nettype none
interface mfrt_in_if;
    import mfrt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [CHANNEL_W-1:0] channel;
    logic [MESSAGE_W-1:0] message;

    modport source (output valid, output opcode, output channel, output message,
                    input ready);
    modport sink   (input valid, input opcode, input channel, input message,
                    output ready);
endinterface
`default_nettype wire

### src/mfrt_out_if.sv
// Result channel interface: status, popped message and remaining time.
`default_nettype none
interface mfrt_out_if;
    import mfrt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [MESSAGE_W-1:0] message_out;
    logic [TIMEOUT_W-1:0] remaining_ms;

    modport source (output valid, output status, output message_out,
                    output remaining_ms, input ready);
    modport sink   (input valid, input status, input message_out,
                    input remaining_ms, output ready);
endinterface
`default_nettype wire

### src/mfrt_cfg_if.sv
// Configuration write channel interface for the timeout register.
`default_nettype none
interface mfrt_cfg_if;
    import mfrt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIMEOUT_W-1:0] timeout_ms;

    modport source (output valid, output timeout_ms, input ready);
    modport sink   (input valid, input timeout_ms, output ready);
endinterface
`default_nettype wire

### src/mfrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/mfrt_ctrl.sv
// Controller: sequences accept and execute steps and owns the result valid flag.
`default_nettype none
module mfrt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mfrt_pkg::t_cmd     o_cmd
);
    import mfrt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be free or freeing this cycle.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### src/mfrt_dpath.sv
// Datapath: ring pointers, wait timers, time counter, message store and result register.
`default_nettype none
module mfrt_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mfrt_pkg::t_cmd                     i_cmd,
    input  wire logic [mfrt_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire logic [mfrt_pkg::CHANNEL_W-1:0]     i_channel,
    input  wire logic [mfrt_pkg::MESSAGE_W-1:0]     i_message,
    input  wire logic                               i_cfg_we,
    input  wire logic [mfrt_pkg::TIMEOUT_W-1:0]     i_cfg_timeout,
    output logic      [2:0]                         o_status,
    output logic      [mfrt_pkg::MESSAGE_W-1:0]     o_message_out,
    output logic      [mfrt_pkg::TIMEOUT_W-1:0]     o_remaining_ms
);
    import mfrt_pkg::*;

    logic [PTR_W-1:0]     r_wp [CHANNELS];
    logic [PTR_W-1:0]     r_rp [CHANNELS];
    logic [CHANNELS-1:0]  r_armed;
    logic [TIME_W-1:0]    r_start [CHANNELS];
    logic [TIME_W-1:0]    r_time;
    logic [TIMEOUT_W-1:0] r_timeout;

    logic [OPCODE_W-1:0]  r_op;
    logic [CH_W-1:0]      r_ch;
    logic [MSG_WIDTH-1:0] r_msg;

    t_status              r_status;
    logic [MSG_WIDTH-1:0] r_message_out;
    logic [TIMEOUT_W-1:0] r_remaining;

    t_status              n_status;
    logic [MSG_WIDTH-1:0] n_message_out;
    logic [TIMEOUT_W-1:0] n_remaining;

    logic [CH_W-1:0]      in_ch;
    logic [PTR_W-1:0]     wp;
    logic [PTR_W-1:0]     rp;
    logic                 is_tick;
    logic                 is_send;
    logic                 ring_full;
    logic                 ring_empty;
    logic [TIME_W-1:0]    elapsed;
    logic                 expired;
    logic                 ram_we;
    logic [MSG_WIDTH-1:0] ram_rdata;

    assign in_ch      = i_channel[CH_W-1:0];
    assign wp         = r_wp[r_ch];
    assign rp         = r_rp[r_ch];
    assign is_tick    = r_op[OP_TICK_BIT];
    assign is_send    = (r_op == OP_SEND);
    assign ring_full  = (PTR_W'(wp + 1'b1) == rp);
    assign ring_empty = (wp == rp);
    assign elapsed    = r_time - r_start[r_ch];
    assign expired    = (elapsed >= {{(TIME_W-TIMEOUT_W){1'b0}}, r_timeout});
    assign ram_we     = i_cmd.exec && is_send && !ring_full;

    // The oldest slot of the addressed ring is read as the request is taken.
    mfrt_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr ({r_ch, wp}),
        .i_wr_data (r_msg),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr ({in_ch, r_rp[in_ch]}),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        n_message_out = '0;
        n_remaining   = '0;
        if (is_tick) begin
            n_status = ST_TICK;
        end else if (is_send) begin
            n_status = ring_full ? ST_FULL : ST_SENT;
        end else if (!ring_empty) begin
            n_status      = ST_RECEIVED;
            n_message_out = ram_rdata;
        end else if (!r_armed[r_ch]) begin
            n_status = ST_WAIT_START;
        end else if (expired) begin
            n_status = ST_TIMEOUT;
        end else begin
            n_status    = ST_WAITING;
            n_remaining = r_timeout - elapsed[TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
            r_armed   <= '0;
            r_time    <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_timeout;
            end
            if (i_cmd.exec) begin
                if (is_tick) begin
                    r_time <= r_time + 1'b1;
                end else if (is_send) begin
                    if (!ring_full) begin
                        r_wp[r_ch] <= PTR_W'(wp + 1'b1);
                    end
                end else if (!ring_empty) begin
                    r_rp[r_ch]    <= PTR_W'(rp + 1'b1);
                    r_armed[r_ch] <= 1'b1;
                end else if (!r_armed[r_ch]) begin
                    r_armed[r_ch] <= 1'b1;
                end else if (expired) begin
                    r_armed[r_ch] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_ch  <= in_ch;
            r_msg <= i_message;
        end
        if (i_cmd.exec) begin
            r_status      <= n_status;
            r_message_out <= n_message_out;
            r_remaining   <= n_remaining;
            // Both a pop and a first wait restart the channel's timer.
            if (n_status == ST_RECEIVED || n_status == ST_WAIT_START) begin
                r_start[r_ch] <= r_time;
            end
        end
    end

    assign o_status       = r_status;
    assign o_message_out  = r_message_out;
    assign o_remaining_ms = r_remaining;

endmodule
`default_nettype wire

### src/mailbox_fifo_with_receive_timeout_unit.sv
// Top level of the multi-channel mailbox unit with receive timeout.
// Sixteen mailboxes of eight slots each (seven usable) share one 128-word message RAM;
// every request (send, receive or millisecond tick) gives exactly one result. Taking a
// request also starts the registered RAM read of the addressed ring's oldest slot, and
// the request is executed once that read data has arrived and the result register is
// free or freeing; no new request is taken until the last one is executed. The result
// sits in an output register, so the next request is taken while the previous result
// waits, and a result that is not taken delays only the execute step after it.
// Timeout writes are always accepted and take effect at once; no clearing pass runs
// after reset.
`default_nettype none
module mailbox_fifo_with_receive_timeout_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mfrt_in_if.sink     i_in,
    mfrt_out_if.source  o_out,
    mfrt_cfg_if.sink    i_cfg
);
    import mfrt_pkg::*;

    t_cmd cmd;

    assign i_cfg.ready = 1'b1;

    mfrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    mfrt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_in.opcode),
        .i_channel      (i_in.channel),
        .i_message      (i_in.message),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_timeout  (i_cfg.timeout_ms),
        .o_status       (o_out.status),
        .o_message_out  (o_out.message_out),
        .o_remaining_ms (o_out.remaining_ms)
    );

endmodule
`default_nettype wire

### src/mfrt_checker.sv
// Port-level assertions for the mailbox unit and the bind that attaches them.
`default_nettype none
module mfrt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [2:0]                         i_status,
    input wire logic [mfrt_pkg::MESSAGE_W-1:0]     i_message_out,
    input wire logic [mfrt_pkg::TIMEOUT_W-1:0]     i_remaining_ms
);
    import mfrt_pkg::*;

    // A pending result must hold until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_message_out) && $stable(i_remaining_ms))
        else $error("result changed before it was taken");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A request is executed before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in execution");

    a_msg_only_on_receive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_RECEIVED) |-> (i_message_out == '0))
        else $error("message word on a result that popped nothing");

    a_left_only_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_WAITING) |-> (i_remaining_ms == '0))
        else $error("remaining time on a result that is not still waiting");

endmodule

bind mailbox_fifo_with_receive_timeout_unit mfrt_checker u_mfrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_message_out  (o_out.message_out),
    .i_remaining_ms (o_out.remaining_ms)
);
`default_nettype wire
